// ===== hdl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
// Depends on nothing; take in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/xxh64_pkg.sv =====
// Package for the XXH64 stream hasher: primes, command and status types, helpers.
// Used by the controller, datapath and top level.
package xxh64_pkg;

    localparam logic [63:0] XP1 = 64'h9E37_79B1_85EB_CA87;
    localparam logic [63:0] XP2 = 64'hC2B2_AE3D_27D4_EB4F;
    localparam logic [63:0] XP3 = 64'h1656_67B1_9E37_79F9;
    localparam logic [63:0] XP4 = 64'h85EB_CA77_C2B2_AE63;
    localparam logic [63:0] XP5 = 64'h27D4_EB2F_1656_67C5;
    localparam logic [63:0] LANE0_OFS = XP1 + XP2;

    localparam logic [3:0] FULL_WORD = 4'd8;
    localparam logic [3:0] HALF_WORD = 4'd4;
    localparam logic [1:0] SLOT_FULL = 2'd3;
    localparam logic [1:0] IDX_WORD  = 2'd3;
    localparam logic [1:0] IDX_LAST  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE, ST_INIT, ST_LANE, ST_MERGE, ST_MLANE, ST_SHORT,
        ST_LEN, ST_TAIL, ST_HALF, ST_BYTE, ST_AVAL, ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        OP_NOP, OP_LD, OP_ADD, OP_XOR, OP_ROT, OP_XSR, OP_MUL
    } t_op;

    typedef enum logic [3:0] {
        SRC_T, SRC_SWORD, SRC_LANE, SRC_LANEROT, SRC_K,
        SRC_SEED, SRC_LEN, SRC_W32, SRC_BYTE
    } t_src;

    typedef enum logic [2:0] {K_P1, K_P2, K_P3, K_P4, K_P5} t_kc;

    typedef enum logic {TGT_T, TGT_H} t_tgt;

    typedef struct packed {
        t_op        op;
        t_tgt       tgt;
        t_src       src;
        t_kc        kc;
        logic [5:0] amt;
        logic [1:0] idx;
        logic [2:0] byte_idx;
        logic       lane_wr;
        logic       lane_init;
        logic       pend_wr;
        logic       load_w;
        logic       len_add;
        logic [3:0] len_inc;
        logic       len_clr;
        logic       hash_ld;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
    } t_stat;

    function automatic logic [63:0] kconst(t_kc kc);
        logic [63:0] k;
        case (kc)
            K_P1: k = XP1;
            K_P2: k = XP2;
            K_P3: k = XP3;
            K_P4: k = XP4;
            K_P5: k = XP5;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic logic [63:0] rotl64(logic [63:0] x, logic [5:0] r);
        logic [127:0] d;
        d = {x, x} << r;
        return d[127:64];
    endfunction

endpackage

// ===== hdl/xxh64_in_if.sv =====
// Input channel of the XXH64 stream hasher: valid/ready with one message word.
// Depends on nothing.
interface xxh64_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last;

    modport source (output valid, output data_word, output byte_count, output last,
                    input ready);
    modport sink   (input valid, input data_word, input byte_count, input last,
                    output ready);
endinterface

// ===== hdl/xxh64_out_if.sv =====
// Output channel of the XXH64 stream hasher: valid/ready with one hash.
// Depends on nothing.
interface xxh64_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash;

    modport source (output valid, output hash, input ready);
    modport sink   (input valid, input hash, output ready);
endinterface

// ===== hdl/xxh64_dpath.sv =====
// Datapath of the XXH64 stream hasher: seed, word buffer, lanes, length, working
// registers and a 32x32 multiplier stepped through partial products. Uses xxh64_pkg.
module xxh64_dpath
    import xxh64_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [63:0] i_cfg_wr_data,
    input  logic [63:0] i_data_word,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic [63:0] o_hash
);

    logic [63:0] r_seed;
    logic [63:0] r_w;
    logic [63:0] r_pend [3];
    logic [63:0] r_lane [4];
    logic [63:0] r_len;
    logic [63:0] r_h;
    logic [63:0] r_t;
    logic [63:0] r_prod;
    logic [63:0] r_macc;
    logic [63:0] r_hash;
    logic [1:0]  r_mstep;

    logic [63:0] w_k;
    logic [63:0] w_a;
    logic [63:0] w_src;
    logic [63:0] w_res;
    logic [63:0] w_sword;
    logic [5:0]  w_mrot;
    logic [31:0] w_ma;
    logic [31:0] w_mb;
    logic [63:0] w_prod;
    logic        w_mul;
    logic        w_done;
    logic        w_wr;

    assign w_k    = kconst(i_cmd.kc);
    assign w_a    = (i_cmd.tgt == TGT_H) ? r_h : r_t;
    assign w_mul  = (i_cmd.op == OP_MUL);
    assign w_done = w_mul && (r_mstep == 2'd3);
    assign w_wr   = (i_cmd.op != OP_NOP) && (!w_mul || w_done);

    always_comb begin
        case (i_cmd.idx)
            2'd0:    begin w_sword = r_pend[0]; w_mrot = 6'd1;  end
            2'd1:    begin w_sword = r_pend[1]; w_mrot = 6'd7;  end
            2'd2:    begin w_sword = r_pend[2]; w_mrot = 6'd12; end
            default: begin w_sword = r_w;       w_mrot = 6'd18; end
        endcase
    end

    always_comb begin
        case (i_cmd.src)
            SRC_T:       w_src = r_t;
            SRC_SWORD:   w_src = w_sword;
            SRC_LANE:    w_src = r_lane[i_cmd.idx];
            SRC_LANEROT: w_src = rotl64(r_lane[i_cmd.idx], w_mrot);
            SRC_K:       w_src = w_k;
            SRC_SEED:    w_src = r_seed;
            SRC_LEN:     w_src = r_len;
            SRC_W32:     w_src = {32'd0, r_w[31:0]};
            SRC_BYTE:    w_src = {56'd0, r_w[{i_cmd.byte_idx, 3'b000} +: 8]};
            default:     w_src = '0;
        endcase
    end

    always_comb begin
        case (r_mstep)
            2'd0:    begin w_ma = w_a[31:0];  w_mb = w_k[31:0];  end
            2'd1:    begin w_ma = w_a[31:0];  w_mb = w_k[63:32]; end
            default: begin w_ma = w_a[63:32]; w_mb = w_k[31:0];  end
        endcase
    end

    assign w_prod = 64'(w_ma) * 64'(w_mb);

    always_comb begin
        case (i_cmd.op)
            OP_LD:   w_res = w_src;
            OP_ADD:  w_res = w_a + w_src;
            OP_XOR:  w_res = w_a ^ w_src;
            OP_ROT:  w_res = rotl64(w_a, i_cmd.amt);
            OP_XSR:  w_res = w_a ^ (w_a >> i_cmd.amt);
            OP_MUL:  w_res = {r_macc[63:32] + r_prod[31:0], r_macc[31:0]};
            default: w_res = w_a;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed  <= '0;
            r_len   <= '0;
            r_mstep <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_seed <= i_cfg_wr_data;
            end
            if (i_cmd.len_clr) begin
                r_len <= '0;
            end else if (i_cmd.len_add) begin
                r_len <= r_len + {60'd0, i_cmd.len_inc};
            end
            if (w_mul) begin
                r_mstep <= r_mstep + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mul) begin
            r_prod <= w_prod;
            case (r_mstep)
                2'd1:    r_macc <= r_prod;
                2'd2:    r_macc[63:32] <= r_macc[63:32] + r_prod[31:0];
                default: r_macc <= r_macc;
            endcase
        end
        if (i_cmd.load_w) begin
            r_w <= i_data_word;
        end
        if (i_cmd.pend_wr) begin
            r_pend[i_cmd.idx] <= i_data_word;
        end
        if (i_cmd.lane_init) begin
            r_lane[0] <= r_seed + LANE0_OFS;
            r_lane[1] <= r_seed + XP2;
            r_lane[2] <= r_seed;
            r_lane[3] <= r_seed - XP1;
        end else if (i_cmd.lane_wr) begin
            r_lane[i_cmd.idx] <= r_t;
        end
        if (w_wr && i_cmd.tgt == TGT_H) begin
            r_h <= w_res;
        end
        if (w_wr && i_cmd.tgt == TGT_T) begin
            r_t <= w_res;
        end
        if (i_cmd.hash_ld) begin
            r_hash <= r_h;
        end
    end

    assign o_stat.mul_done = w_done;
    assign o_hash          = r_hash;

endmodule

// ===== hdl/xxh64_ctrl.sv =====
// Controller of the XXH64 stream hasher: sequences stripes, merge, tails and
// avalanche as commands to the datapath. Uses xxh64_pkg.
module xxh64_ctrl
    import xxh64_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_last,
    input  logic [3:0] i_in_byte_count,
    output logic       o_in_ready,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);

    t_state     r_state, n_state;
    logic [2:0] r_step, n_step;
    logic [1:0] r_idx, n_idx;
    logic [2:0] r_byte, n_byte;
    logic [1:0] r_slot, n_slot;
    logic [3:0] r_bc, n_bc;
    logic       r_seen, n_seen;
    logic       r_fin, n_fin;
    logic       r_ovalid, n_ovalid;

    t_cmd       w_cmd;
    logic [2:0] w_last_step;
    logic       w_step_go;
    logic       w_phase_end;
    logic       w_out_free;
    logic [3:0] w_bc_sat;
    t_state     w_tail_state;

    function automatic t_cmd mk(t_op op, t_tgt tgt, t_src src, t_kc kc, logic [5:0] amt);
        t_cmd c;
        c     = '0;
        c.op  = op;
        c.tgt = tgt;
        c.src = src;
        c.kc  = kc;
        c.amt = amt;
        return c;
    endfunction

    assign w_bc_sat   = (i_in_byte_count > FULL_WORD) ? FULL_WORD : i_in_byte_count;
    assign w_out_free = !r_ovalid || i_out_ready;

    // Outputs and commands
    always_comb begin
        w_cmd       = '0;
        w_last_step = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    w_cmd.load_w  = 1'b1;
                    w_cmd.len_add = 1'b1;
                    w_cmd.len_inc = i_in_last ? w_bc_sat : FULL_WORD;
                    w_cmd.pend_wr = !i_in_last && (r_slot != SLOT_FULL);
                end
            end
            ST_INIT: begin
                w_cmd.lane_init = 1'b1;
            end
            ST_LANE: begin
                w_last_step = 3'd5;
                case (r_step)
                    3'd0: w_cmd = mk(OP_LD,  TGT_T, SRC_SWORD, K_P1, 6'd0);
                    3'd1: w_cmd = mk(OP_MUL, TGT_T, SRC_T,     K_P2, 6'd0);
                    3'd2: w_cmd = mk(OP_ADD, TGT_T, SRC_LANE,  K_P1, 6'd0);
                    3'd3: w_cmd = mk(OP_ROT, TGT_T, SRC_T,     K_P1, 6'd31);
                    3'd4: w_cmd = mk(OP_MUL, TGT_T, SRC_T,     K_P1, 6'd0);
                    default: w_cmd.lane_wr = 1'b1;
                endcase
            end
            ST_MERGE: begin
                w_cmd = mk((r_idx == 2'd0) ? OP_LD : OP_ADD, TGT_H, SRC_LANEROT,
                           K_P1, 6'd0);
            end
            ST_MLANE: begin
                w_last_step = 3'd6;
                case (r_step)
                    3'd0: w_cmd = mk(OP_LD,  TGT_T, SRC_LANE, K_P1, 6'd0);
                    3'd1: w_cmd = mk(OP_MUL, TGT_T, SRC_T,    K_P2, 6'd0);
                    3'd2: w_cmd = mk(OP_ROT, TGT_T, SRC_T,    K_P1, 6'd31);
                    3'd3: w_cmd = mk(OP_MUL, TGT_T, SRC_T,    K_P1, 6'd0);
                    3'd4: w_cmd = mk(OP_XOR, TGT_H, SRC_T,    K_P1, 6'd0);
                    3'd5: w_cmd = mk(OP_MUL, TGT_H, SRC_T,    K_P1, 6'd0);
                    default: w_cmd = mk(OP_ADD, TGT_H, SRC_K, K_P4, 6'd0);
                endcase
            end
            ST_SHORT: begin
                w_last_step = 3'd1;
                case (r_step)
                    3'd0:    w_cmd = mk(OP_LD,  TGT_H, SRC_SEED, K_P1, 6'd0);
                    default: w_cmd = mk(OP_ADD, TGT_H, SRC_K,    K_P5, 6'd0);
                endcase
            end
            ST_LEN: begin
                w_cmd = mk(OP_ADD, TGT_H, SRC_LEN, K_P1, 6'd0);
            end
            ST_TAIL: begin
                w_last_step = 3'd7;
                case (r_step)
                    3'd0: w_cmd = mk(OP_LD,  TGT_T, SRC_SWORD, K_P1, 6'd0);
                    3'd1: w_cmd = mk(OP_MUL, TGT_T, SRC_T,     K_P2, 6'd0);
                    3'd2: w_cmd = mk(OP_ROT, TGT_T, SRC_T,     K_P1, 6'd31);
                    3'd3: w_cmd = mk(OP_MUL, TGT_T, SRC_T,     K_P1, 6'd0);
                    3'd4: w_cmd = mk(OP_XOR, TGT_H, SRC_T,     K_P1, 6'd0);
                    3'd5: w_cmd = mk(OP_ROT, TGT_H, SRC_T,     K_P1, 6'd27);
                    3'd6: w_cmd = mk(OP_MUL, TGT_H, SRC_T,     K_P1, 6'd0);
                    default: w_cmd = mk(OP_ADD, TGT_H, SRC_K,  K_P4, 6'd0);
                endcase
            end
            ST_HALF: begin
                w_last_step = 3'd5;
                case (r_step)
                    3'd0: w_cmd = mk(OP_LD,  TGT_T, SRC_W32, K_P1, 6'd0);
                    3'd1: w_cmd = mk(OP_MUL, TGT_T, SRC_T,   K_P1, 6'd0);
                    3'd2: w_cmd = mk(OP_XOR, TGT_H, SRC_T,   K_P1, 6'd0);
                    3'd3: w_cmd = mk(OP_ROT, TGT_H, SRC_T,   K_P1, 6'd23);
                    3'd4: w_cmd = mk(OP_MUL, TGT_H, SRC_T,   K_P2, 6'd0);
                    default: w_cmd = mk(OP_ADD, TGT_H, SRC_K, K_P3, 6'd0);
                endcase
            end
            ST_BYTE: begin
                w_last_step = 3'd4;
                case (r_step)
                    3'd0: w_cmd = mk(OP_LD,  TGT_T, SRC_BYTE, K_P1, 6'd0);
                    3'd1: w_cmd = mk(OP_MUL, TGT_T, SRC_T,    K_P5, 6'd0);
                    3'd2: w_cmd = mk(OP_XOR, TGT_H, SRC_T,    K_P1, 6'd0);
                    3'd3: w_cmd = mk(OP_ROT, TGT_H, SRC_T,    K_P1, 6'd11);
                    default: w_cmd = mk(OP_MUL, TGT_H, SRC_T, K_P1, 6'd0);
                endcase
            end
            ST_AVAL: begin
                w_last_step = 3'd4;
                case (r_step)
                    3'd0: w_cmd = mk(OP_XSR, TGT_H, SRC_T, K_P1, 6'd33);
                    3'd1: w_cmd = mk(OP_MUL, TGT_H, SRC_T, K_P2, 6'd0);
                    3'd2: w_cmd = mk(OP_XSR, TGT_H, SRC_T, K_P1, 6'd29);
                    3'd3: w_cmd = mk(OP_MUL, TGT_H, SRC_T, K_P3, 6'd0);
                    default: w_cmd = mk(OP_XSR, TGT_H, SRC_T, K_P1, 6'd32);
                endcase
            end
            ST_OUT: begin
                w_cmd.hash_ld = w_out_free;
                w_cmd.len_clr = w_out_free;
            end
            default: begin
                w_cmd = '0;
            end
        endcase
        w_cmd.idx      = (r_state == ST_IDLE) ? r_slot : r_idx;
        w_cmd.byte_idx = r_byte;
        w_step_go      = (w_cmd.op != OP_MUL) || i_stat.mul_done;
        w_phase_end    = w_step_go && (r_step == w_last_step);
    end

    assign o_cmd       = w_cmd;
    assign o_out_valid = r_ovalid;

    // Next state
    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_idx    = r_idx;
        n_byte   = r_byte;
        n_slot   = r_slot;
        n_bc     = r_bc;
        n_seen   = r_seen;
        n_fin    = r_fin;
        n_ovalid = r_ovalid && !i_out_ready;

        if (r_bc == FULL_WORD) begin
            w_tail_state = ST_TAIL;
        end else if (r_bc >= HALF_WORD) begin
            w_tail_state = ST_HALF;
        end else if (r_bc != 4'd0) begin
            w_tail_state = ST_BYTE;
        end else begin
            w_tail_state = ST_AVAL;
        end

        if (r_state != ST_IDLE && r_state != ST_OUT && w_step_go) begin
            n_step = w_phase_end ? 3'd0 : r_step + 3'd1;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_idx = 2'd0;
                    if (!i_in_last) begin
                        if (r_slot != SLOT_FULL) begin
                            n_slot = r_slot + 2'd1;
                        end else begin
                            n_fin   = 1'b0;
                            n_state = r_seen ? ST_LANE : ST_INIT;
                        end
                    end else if (w_bc_sat == FULL_WORD && r_slot == SLOT_FULL) begin
                        n_bc    = 4'd0;
                        n_fin   = 1'b1;
                        n_state = r_seen ? ST_LANE : ST_INIT;
                    end else begin
                        n_bc    = w_bc_sat;
                        n_state = r_seen ? ST_MERGE : ST_SHORT;
                    end
                end
            end
            ST_INIT: begin
                n_seen  = 1'b1;
                n_state = ST_LANE;
            end
            ST_LANE: begin
                if (w_phase_end) begin
                    if (r_idx != IDX_LAST) begin
                        n_idx = r_idx + 2'd1;
                    end else begin
                        n_idx   = 2'd0;
                        n_slot  = 2'd0;
                        n_state = r_fin ? ST_MERGE : ST_IDLE;
                    end
                end
            end
            ST_MERGE: begin
                if (r_idx != IDX_LAST) begin
                    n_idx = r_idx + 2'd1;
                end else begin
                    n_idx   = 2'd0;
                    n_state = ST_MLANE;
                end
            end
            ST_MLANE: begin
                if (w_phase_end) begin
                    if (r_idx != IDX_LAST) begin
                        n_idx = r_idx + 2'd1;
                    end else begin
                        n_state = ST_LEN;
                    end
                end
            end
            ST_SHORT: begin
                if (w_phase_end) begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN: begin
                n_byte = 3'd0;
                if (r_slot != 2'd0) begin
                    n_idx   = 2'd0;
                    n_state = ST_TAIL;
                end else begin
                    n_idx   = IDX_WORD;
                    n_state = w_tail_state;
                end
            end
            ST_TAIL: begin
                if (w_phase_end) begin
                    if (r_idx == IDX_WORD) begin
                        n_state = ST_AVAL;
                    end else if ((r_idx + 2'd1) < r_slot) begin
                        n_idx = r_idx + 2'd1;
                    end else begin
                        n_idx   = IDX_WORD;
                        n_state = w_tail_state;
                    end
                end
            end
            ST_HALF: begin
                if (w_phase_end) begin
                    if (r_bc > HALF_WORD) begin
                        n_byte  = 3'd4;
                        n_state = ST_BYTE;
                    end else begin
                        n_state = ST_AVAL;
                    end
                end
            end
            ST_BYTE: begin
                if (w_phase_end) begin
                    if (({1'b0, r_byte} + 4'd1) < r_bc) begin
                        n_byte = r_byte + 3'd1;
                    end else begin
                        n_state = ST_AVAL;
                    end
                end
            end
            ST_AVAL: begin
                if (w_phase_end) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_slot   = 2'd0;
                    n_seen   = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= '0;
            r_idx    <= '0;
            r_byte   <= '0;
            r_slot   <= '0;
            r_bc     <= '0;
            r_seen   <= 1'b0;
            r_fin    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_idx    <= n_idx;
            r_byte   <= n_byte;
            r_slot   <= n_slot;
            r_bc     <= n_bc;
            r_seen   <= n_seen;
            r_fin    <= n_fin;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

// ===== hdl/xxhash64_stream_hasher.sv =====
// Top level of the XXH64 stream hasher: joins controller and datapath.
// Uses xxh64_pkg, xxh64_in_if, xxh64_out_if, xxh64_ctrl and xxh64_dpath.
//
// i_in carries a message as 64-bit little-endian words; last marks the final
// transaction, whose byte_count (0..8, larger saturates to 8) gives its valid
// bytes. Every other transaction counts as eight bytes. o_out returns one hash
// per message. The seed register is written through i_cfg_wr_en/i_cfg_wr_data
// and takes effect for the stripes and short-message path that follow.
// One shared 32x32 multiplier builds each 64-bit product from partial products.
// A word into a free buffer slot is only stored; the fourth word of a stripe
// also runs the rounds of all four lanes (after a lane init on the first stripe
// of a message). The final transaction runs the lane rounds when it completes a
// stripe, then the merge and length add (a short path when shorter than one
// stripe), a round per buffered word and for a full last word, a four-byte round,
// a round per single byte and the avalanche, between accept and output states.
// Synchronous reset clears the buffer count, length and output valid.
// The hash sits in an output register until taken; the next message is
// accepted meanwhile, and only its own result waits while o_out is stalled.
module xxhash64_stream_hasher
    import xxh64_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [63:0] i_cfg_wr_data,
    xxh64_in_if.sink    i_in,
    xxh64_out_if.source o_out
);

    t_cmd  w_cmd;
    t_stat w_stat;

    xxh64_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in.valid),
        .i_in_last       (i_in.last),
        .i_in_byte_count (i_in.byte_count),
        .o_in_ready      (i_in.ready),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .i_stat          (w_stat),
        .o_cmd           (w_cmd)
    );

    xxh64_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_data_word   (i_in.data_word),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_hash        (o_out.hash)
    );

endmodule

// ===== hdl/xxh64_checker.sv =====
// Port-level checker for the XXH64 stream hasher, bound to the top level.
// Uses assert_macros.svh.
`include "assert_macros.svh"

module xxh64_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_last,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_hash
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_hash), "stalled hash changed or dropped")
    `ASSERT_NEXT(a_no_result_on_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !$rose(i_out_valid), "result raised right after an input transaction")
    `ASSERT_NEXT(a_busy_after_last, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_last, !i_in_ready, "ready right after final transaction")

endmodule

bind xxhash64_stream_hasher xxh64_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.last),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_hash  (o_out.hash)
);
